// ===== src/rpr_pkg.sv =====
// Shared types, constants and helper functions of the per-connection reply reorder block.
package rpr_pkg;

	localparam int NUM_CONN    = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_BITS    = 8;

	localparam int CONN_W = (NUM_CONN > 1) ? $clog2(NUM_CONN) : 1;
	localparam int POS_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS  = NUM_CONN * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);

	localparam logic [CONN_W-1:0] CONN_LAST = CONN_W'(NUM_CONN - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);

	localparam logic OP_NEW      = 1'b0;
	localparam logic OP_COMPLETE = 1'b1;

	localparam logic KIND_RELEASE = 1'b0;
	localparam logic KIND_DROP    = 1'b1;

	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [CONN_W-1:0]   conn_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [ADDR_W-1:0]   addr_t;

	typedef struct packed {
		logic rdy;
		tag_t tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_NEW,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_REL_RD,
		S_REL_CHK,
		S_REL_LAST
	} state_t;

	typedef struct packed {
		logic   we;
		addr_t  waddr;
		entry_t wdata;
		logic   re;
		addr_t  raddr;
	} ram_req_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] out_conn;
		logic [7:0] out_tag;
		logic       kind;
		logic       last;
	} emit_t;

	function automatic tag_t tag_in(input logic [7:0] t);
		logic [15:0] wide;
		wide = {8'b0, t};
		return wide[TAG_BITS-1:0];
	endfunction

	function automatic logic [7:0] tag_out(input tag_t t);
		logic [15:0] wide;
		wide = 16'(t);
		return wide[7:0];
	endfunction

	function automatic conn_t conn_in(input logic [2:0] c);
		logic [7:0] wide;
		wide = {5'b0, c};
		return wide[CONN_W-1:0];
	endfunction

	function automatic logic [2:0] conn_out(input conn_t c);
		logic [7:0] wide;
		wide = 8'(c);
		return wide[2:0];
	endfunction

	// Ring position of head plus offset; the sum stays below twice the depth.
	function automatic pos_t ring_add(input pos_t head, input pos_t off);
		logic [POS_W:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= (POS_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (POS_W+1)'(QUEUE_DEPTH);
		end
		return sum[POS_W-1:0];
	endfunction

	function automatic addr_t slot(input conn_t c, input pos_t p);
		return ADDR_W'(int'(c) * QUEUE_DEPTH + int'(p));
	endfunction

endpackage

// ===== src/rpr_in_if.sv =====
// Input channel of the reply reorder block: valid, ready and one request item.
interface rpr_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [2:0] conn;
	logic [7:0] tag;
	logic       immediate;

	modport source (output valid, output op, output conn, output tag, output immediate,
		input ready);
	modport sink (input valid, input op, input conn, input tag, input immediate,
		output ready);
endinterface

// ===== src/rpr_out_if.sv =====
// Output channel of the reply reorder block: valid, ready and one result item.
interface rpr_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] out_conn;
	logic [7:0] out_tag;
	logic       kind;
	logic       last;

	modport source (output valid, output out_conn, output out_tag, output kind, output last,
		input ready);
	modport sink (input valid, input out_conn, input out_tag, input kind, input last,
		output ready);
endinterface

// ===== src/rpr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module rpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/rpr_ctrl.sv =====
// Sequencer that appends, searches and releases queue entries through the entry RAM.
module rpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	rpr_in_if.sink            req,
	input  logic              out_free,
	output rpr_pkg::emit_t    emit,
	output rpr_pkg::ram_req_t ram,
	input  rpr_pkg::entry_t   rd
);

	rpr_pkg::state_t state_q, state_d;

	rpr_pkg::pos_t head_q [rpr_pkg::NUM_CONN];
	rpr_pkg::cnt_t count_q [rpr_pkg::NUM_CONN];

	logic          op_q;
	logic          imm_q;
	logic          conn_ok_q;
	rpr_pkg::conn_t cur_conn_q;
	rpr_pkg::tag_t tag_q;
	rpr_pkg::tag_t pend_q;
	rpr_pkg::cnt_t pos_q;

	rpr_pkg::pos_t cur_head;
	rpr_pkg::cnt_t cur_cnt;
	rpr_pkg::addr_t srch_addr;

	logic accept;
	logic push;
	logic pop;
	logic adv_conn;
	logic pos_inc;
	logic pend_ld;

	assign cur_head  = head_q[cur_conn_q];
	assign cur_cnt   = count_q[cur_conn_q];
	assign srch_addr = rpr_pkg::slot(cur_conn_q,
		rpr_pkg::ring_add(cur_head, pos_q[rpr_pkg::POS_W-1:0]));

	assign req.ready = (state_q == rpr_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		emit     = '0;
		ram      = '0;
		push     = 1'b0;
		pop      = 1'b0;
		adv_conn = 1'b0;
		pos_inc  = 1'b0;
		pend_ld  = 1'b0;
		case (state_q)
			rpr_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (req.op == rpr_pkg::OP_COMPLETE) ? rpr_pkg::S_SRCH_RD
						: rpr_pkg::S_NEW;
				end
			end
			rpr_pkg::S_NEW: begin
				if (!conn_ok_q) begin
					state_d = rpr_pkg::S_IDLE;
				end else if ((imm_q && cur_cnt == '0) || cur_cnt == rpr_pkg::CNT_FULL) begin
					if (out_free) begin
						emit.valid    = 1'b1;
						emit.out_conn = rpr_pkg::conn_out(cur_conn_q);
						emit.out_tag  = rpr_pkg::tag_out(tag_q);
						emit.kind     = (cur_cnt == '0) ? rpr_pkg::KIND_RELEASE
							: rpr_pkg::KIND_DROP;
						emit.last     = 1'b1;
						state_d       = rpr_pkg::S_IDLE;
					end
				end else begin
					ram.we        = 1'b1;
					ram.waddr     = rpr_pkg::slot(cur_conn_q,
						rpr_pkg::ring_add(cur_head, cur_cnt[rpr_pkg::POS_W-1:0]));
					ram.wdata.rdy = imm_q;
					ram.wdata.tag = tag_q;
					push          = 1'b1;
					state_d       = rpr_pkg::S_IDLE;
				end
			end
			rpr_pkg::S_SRCH_RD: begin
				if (pos_q == cur_cnt) begin
					if (cur_conn_q == rpr_pkg::CONN_LAST) begin
						state_d = rpr_pkg::S_IDLE;
					end else begin
						adv_conn = 1'b1;
					end
				end else begin
					ram.re    = 1'b1;
					ram.raddr = srch_addr;
					state_d   = rpr_pkg::S_SRCH_CHK;
				end
			end
			rpr_pkg::S_SRCH_CHK: begin
				if (!rd.rdy && rd.tag == tag_q) begin
					if (pos_q != '0) begin
						ram.we        = 1'b1;
						ram.waddr     = srch_addr;
						ram.wdata.rdy = 1'b1;
						ram.wdata.tag = rd.tag;
						state_d       = rpr_pkg::S_IDLE;
					end else begin
						pend_ld = 1'b1;
						pop     = 1'b1;
						state_d = (cur_cnt == rpr_pkg::CNT_W'(1)) ? rpr_pkg::S_REL_LAST
							: rpr_pkg::S_REL_RD;
					end
				end else begin
					pos_inc = 1'b1;
					state_d = rpr_pkg::S_SRCH_RD;
				end
			end
			rpr_pkg::S_REL_RD: begin
				ram.re    = 1'b1;
				ram.raddr = rpr_pkg::slot(cur_conn_q, cur_head);
				state_d   = rpr_pkg::S_REL_CHK;
			end
			rpr_pkg::S_REL_CHK: begin
				if (out_free) begin
					emit.valid    = 1'b1;
					emit.out_conn = rpr_pkg::conn_out(cur_conn_q);
					emit.out_tag  = rpr_pkg::tag_out(pend_q);
					emit.kind     = rpr_pkg::KIND_RELEASE;
					if (rd.rdy) begin
						emit.last = 1'b0;
						pend_ld   = 1'b1;
						pop       = 1'b1;
						state_d   = (cur_cnt == rpr_pkg::CNT_W'(1)) ? rpr_pkg::S_REL_LAST
							: rpr_pkg::S_REL_RD;
					end else begin
						emit.last = 1'b1;
						state_d   = rpr_pkg::S_IDLE;
					end
				end
			end
			rpr_pkg::S_REL_LAST: begin
				if (out_free) begin
					emit.valid    = 1'b1;
					emit.out_conn = rpr_pkg::conn_out(cur_conn_q);
					emit.out_tag  = rpr_pkg::tag_out(pend_q);
					emit.kind     = rpr_pkg::KIND_RELEASE;
					emit.last     = 1'b1;
					state_d       = rpr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rpr_pkg::S_IDLE;
			end
		endcase
	end

	// Queue heads and fill counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rpr_pkg::NUM_CONN; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (push) begin
			count_q[cur_conn_q] <= cur_cnt + rpr_pkg::CNT_W'(1);
		end else if (pop) begin
			head_q[cur_conn_q]  <= rpr_pkg::ring_add(cur_head, rpr_pkg::POS_W'(1));
			count_q[cur_conn_q] <= cur_cnt - rpr_pkg::CNT_W'(1);
		end
	end

	// Working registers of the item in progress.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= req.op;
			imm_q      <= req.immediate;
			conn_ok_q  <= (int'(req.conn) < rpr_pkg::NUM_CONN);
			cur_conn_q <= (req.op == rpr_pkg::OP_COMPLETE) ? '0 : rpr_pkg::conn_in(req.conn);
			tag_q      <= rpr_pkg::tag_in(req.tag);
			pos_q      <= '0;
		end else if (adv_conn) begin
			cur_conn_q <= cur_conn_q + rpr_pkg::CONN_W'(1);
			pos_q      <= '0;
		end else if (pos_inc) begin
			pos_q <= pos_q + rpr_pkg::CNT_W'(1);
		end
		if (pend_ld) begin
			pend_q <= rd.tag;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> out_free)
		else $error("result issued while the output register is occupied");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cur_cnt != '0)
		else $error("pop from an empty queue");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cur_cnt < rpr_pkg::CNT_FULL)
		else $error("append to a full queue");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == rpr_pkg::S_NEW || state_q == rpr_pkg::S_SRCH_RD))
		else $error("accepted item was not dispatched");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && !emit.last) |=> state_q != rpr_pkg::S_IDLE)
		else $error("release run ended without a last result");

	a_op_new_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpr_pkg::S_NEW) |-> op_q == rpr_pkg::OP_NEW)
		else $error("completion item entered the append path");

endmodule

// ===== src/per_connection_reply_reorder.sv =====
// Top level of the per-connection reply reorder block: sequencer, entry RAM and result register.
//
// The block keeps one in-order reply queue of QUEUE_DEPTH entries for each of NUM_CONN
// connections, all held in a single entry RAM (tag plus ready mark) with a registered read,
// while queue heads and fill counts sit in flip-flops that reset clears. Items are handled
// one at a time. A new reply is accepted in S_IDLE; S_NEW then either appends it to the
// RAM or issues its immediate release or its overflow drop, waiting while the output
// register is full. A completion walks the queues by reading the RAM one entry at a time
// (address in S_SRCH_RD, then compare in S_SRCH_CHK), from connection 0 upward and head
// to tail, moving on to the next connection whenever a queue has been searched through.
// A match away from the head is written back as ready and ends the item; a match at the
// head starts a release run that reads the next head entry and puts out one result for
// each entry released, the last of the run flagged. Results pass through an output register, so
// a finished result may wait on the output while the next item is accepted; the sequencer
// only stalls when it has another result to place and that register is still full.
// Completion tags that match no waiting entry and new replies for a connection beyond
// NUM_CONN give no result. The entry RAM needs no clearing: only occupied queue slots,
// which an append has written, are ever read.
module per_connection_reply_reorder (
	input  logic       clk,
	input  logic       arst_n,
	rpr_in_if.sink     req,
	rpr_out_if.source  rsp
);

	rpr_pkg::emit_t    emit;
	rpr_pkg::ram_req_t ram;
	logic [rpr_pkg::ENTRY_W-1:0] ram_rdata;
	logic out_free;

	logic       out_valid_q;
	logic [2:0] out_conn_q;
	logic [7:0] out_tag_q;
	logic       kind_q;
	logic       last_q;

	// The output register frees up in the same cycle in which its item is taken.
	assign out_free = !out_valid_q || rsp.ready;

	rpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.emit     (emit),
		.ram      (ram),
		.rd       (ram_rdata)
	);

	rpr_ram #(
		.WIDTH (rpr_pkg::ENTRY_W),
		.DEPTH (rpr_pkg::SLOTS)
	) u_entries (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.re    (ram.re),
		.raddr (ram.raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_conn_q <= emit.out_conn;
			out_tag_q  <= emit.out_tag;
			kind_q     <= emit.kind;
			last_q     <= emit.last;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.out_conn = out_conn_q;
	assign rsp.out_tag  = out_tag_q;
	assign rsp.kind     = kind_q;
	assign rsp.last     = last_q;

	a_drop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.kind == rpr_pkg::KIND_DROP) |-> rsp.last)
		else $error("dropped reply not flagged as last");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second item accepted before the first was dispatched");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |=> rsp.valid)
		else $error("issued result did not reach the output");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the per-connection reply reorder block.
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 2;
	localparam int RANDOM_ITEMS = 245;
	localparam int CYCLE_LIMIT  = 1_000_000;
	// A completion may walk every queue slot before it matches,
	// so the tail wait after the last result covers one full search with margin.
	localparam int TAIL_CYCLES  = 2 * rpr_pkg::SLOTS + 64;
	localparam int DRAIN_LIMIT  = 40_000;

	// One request item as it is driven onto the input channel.
	typedef struct packed {
		logic       op;
		logic [2:0] conn;
		logic [7:0] tag;
		logic       immediate;
	} req_t;

	// One result item as it leaves the output channel.
	typedef struct packed {
		logic [2:0] conn;
		logic [7:0] tag;
		logic       kind;
		logic       last;
	} reply_t;

	// One waiting reply in the prediction of a connection's queue.
	typedef struct packed {
		rpr_pkg::tag_t tag;
		logic          rdy;
	} pend_t;

	// One row of the directed part. A pinned row carries its expected result right here
	// (at most one) instead of taking it from the predictor.
	typedef struct packed {
		logic       op;
		logic [2:0] conn;
		logic [7:0] tag;
		logic       immediate;
		logic       pinned;
		logic       pin_one;
		reply_t     pin;
	} step_t;

	localparam reply_t NO_REPLY = '0;
	localparam int     NUM_STEPS = 25;

	// Directed part. Connection 3 gets a delayed head, a ready entry and a second delayed
	// entry; the second completes first and is only marked, then the head completes and
	// the whole run drains. Connection 7 is then filled with a delayed head and fifteen
	// ready entries, overflows once, and drains all sixteen on one completion.
	localparam step_t DIRECTED_STEPS [NUM_STEPS] = '{
		'{rpr_pkg::OP_NEW, 3'd0, 8'h00, 1'b1, 1'b1, 1'b1,
			'{3'd0, 8'h00, rpr_pkg::KIND_RELEASE, 1'b1}},
		'{rpr_pkg::OP_COMPLETE, 3'd5, 8'h55, 1'b1, 1'b1, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd3, 8'h10, 1'b0, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd3, 8'h11, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd3, 8'h12, 1'b0, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_COMPLETE, 3'd0, 8'h12, 1'b0, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_COMPLETE, 3'd2, 8'h10, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h80, 1'b0, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h81, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h82, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h83, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h84, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h85, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h86, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h87, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h88, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h89, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h8A, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h8B, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h8C, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h8D, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h8E, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW,      3'd7, 8'h8F, 1'b1, 1'b0, 1'b0, NO_REPLY},
		'{rpr_pkg::OP_NEW, 3'd7, 8'hFF, 1'b0, 1'b1, 1'b1,
			'{3'd7, 8'hFF, rpr_pkg::KIND_DROP, 1'b1}},
		'{rpr_pkg::OP_COMPLETE, 3'd0, 8'h80, 1'b0, 1'b0, 1'b0, NO_REPLY}
	};

	logic clk = 1'b0;
	logic arst_n;

	rpr_in_if  req_if ();
	rpr_out_if rsp_if ();

	per_connection_reply_reorder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #(CLK_HALF) clk = ~clk;

	// Predicted contents of every connection's reply queue, head first.
	pend_t  conn_queue [rpr_pkg::NUM_CONN][$];
	// Results still owed by the block, oldest first.
	reply_t due_replies [$];

	int  mismatches  = 0;
	int  cycle_count = 0;
	// While set, neither side inserts idle cycles.
	logic steady = 1'b0;

	// Idle length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Works out the results that one accepted request causes and updates the queues.
	task automatic predict_replies(input req_t it, output reply_t res[$]);
		rpr_pkg::tag_t t;
		int     c;
		int     hit_c;
		int     hit_p;
		pend_t  head;
		reply_t r;
		res = {};
		t = rpr_pkg::tag_t'(it.tag);
		if (it.op == rpr_pkg::OP_NEW) begin
			c = int'(it.conn);
			if (c >= rpr_pkg::NUM_CONN) begin
				return;
			end
			if (it.immediate && conn_queue[c].size() == 0) begin
				r = '{it.conn, 8'(t), rpr_pkg::KIND_RELEASE, 1'b1};
				res.insert(res.size(), r);
			end else if (conn_queue[c].size() >= rpr_pkg::QUEUE_DEPTH) begin
				r = '{it.conn, 8'(t), rpr_pkg::KIND_DROP, 1'b1};
				res.insert(res.size(), r);
			end else begin
				conn_queue[c].insert(conn_queue[c].size(), pend_t'{t, it.immediate});
			end
			return;
		end
		// Completion: first not-yet-ready entry with this tag, connection 0 upward,
		// each queue from head to tail.
		hit_c = -1;
		hit_p = -1;
		for (int qc = 0; qc < rpr_pkg::NUM_CONN && hit_c < 0; qc++) begin
			for (int qp = 0; qp < conn_queue[qc].size() && hit_c < 0; qp++) begin
				if (!conn_queue[qc][qp].rdy && conn_queue[qc][qp].tag == t) begin
					hit_c = qc;
					hit_p = qp;
				end
			end
		end
		if (hit_c < 0) begin
			return;
		end
		if (hit_p != 0) begin
			conn_queue[hit_c][hit_p].rdy = 1'b1;
			return;
		end
		do begin
			head = conn_queue[hit_c][0];
			conn_queue[hit_c].delete(0);
			r = '{3'(hit_c), 8'(head.tag), rpr_pkg::KIND_RELEASE, 1'b0};
			res.insert(res.size(), r);
		end while (conn_queue[hit_c].size() != 0 && conn_queue[hit_c][0].rdy);
		res[res.size()-1].last = 1'b1;
	endtask

	// Random request: mostly well-formed traffic (new replies, completions of replies that
	// are really waiting), the rest completions with arbitrary tags. During the hot phase
	// most new replies pile onto one connection so that its queue overflows now and then.
	function automatic req_t random_request(input logic hot);
		req_t  it;
		rpr_pkg::tag_t waiting [$];
		int    roll;
		for (int c = 0; c < rpr_pkg::NUM_CONN; c++) begin
			for (int p = 0; p < conn_queue[c].size(); p++) begin
				if (!conn_queue[c][p].rdy) begin
					waiting.insert(waiting.size(), conn_queue[c][p].tag);
				end
			end
		end
		it.conn      = 3'($urandom_range(0, 7));
		it.tag       = 8'($urandom_range(0, 255));
		it.immediate = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (roll < 52 || (waiting.size() == 0 && roll < 80)) begin
			it.op = rpr_pkg::OP_NEW;
			it.immediate = ($urandom_range(0, 99) < 40);
			if (hot && $urandom_range(0, 3) != 0) begin
				it.conn = 3'd6;
			end
		end else begin
			it.op = rpr_pkg::OP_COMPLETE;
			if (roll < 90 && waiting.size() != 0) begin
				it.tag = 8'(waiting[$urandom_range(0, waiting.size() - 1)]);
			end
		end
		return it;
	endfunction

	// Drives one request, holds it until the block takes it, then records what it owes.
	task automatic send_item(input req_t it, input logic pinned, input logic pin_one,
			input reply_t pin);
		reply_t got [$];
		req_if.valid     <= 1'b1;
		req_if.op        <= it.op;
		req_if.conn      <= it.conn;
		req_if.tag       <= it.tag;
		req_if.immediate <= it.immediate;
		@(posedge clk);
		while (!req_if.ready) begin
			@(posedge clk);
		end
		predict_replies(it, got);
		if (pinned) begin
			if (pin_one) begin
				due_replies.insert(due_replies.size(), pin);
			end
		end else begin
			foreach (got[k]) begin
				due_replies.insert(due_replies.size(), got[k]);
			end
		end
	endtask

	// Idles the sender before the next item. A pause also waits until every owed result
	// has come back, so the block starts the next item from a quiet state.
	task automatic hold_off(input logic pause);
		int gap;
		gap = pick_gap();
		if (gap > 0 || pause) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (pause) begin
			@(posedge clk);
			while (due_replies.size() != 0) begin
				@(posedge clk);
			end
		end
	endtask

	// Stimulus and end of run.
	initial begin
		step_t row;
		req_t  it;
		int    waited;
		arst_n           <= 1'b0;
		req_if.valid     <= 1'b0;
		req_if.op        <= rpr_pkg::OP_NEW;
		req_if.conn      <= '0;
		req_if.tag       <= '0;
		req_if.immediate <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_STEPS; i++) begin
			row = DIRECTED_STEPS[i];
			it  = '{row.op, row.conn, row.tag, row.immediate};
			hold_off(1'b0);
			send_item(it, row.pinned, row.pin_one, row.pin);
		end

		// Random part. Every third block of 45 items runs without idle cycles, items 100
		// to 159 crowd one connection, and the block is let run dry at the start and once
		// halfway through.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = ((i / 45) % 3 == 1);
			hold_off(i == 0 || i == RANDOM_ITEMS / 2);
			it = random_request(i >= 100 && i < 160);
			send_item(it, 1'b0, 1'b0, NO_REPLY);
		end
		steady = 1'b0;
		req_if.valid <= 1'b0;

		waited = 0;
		while (due_replies.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		// Anything the block still puts out now is caught as an unexpected result.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_replies.size() != 0) begin
			$error("%0d expected results never arrived", due_replies.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Receiver: ready mostly high, dropped for gaps of random length.
	initial begin
		int gap;
		rsp_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) begin
			@(posedge clk);
		end
		forever begin
			gap = pick_gap();
			if (gap == 0) begin
				rsp_if.ready <= 1'b1;
				@(posedge clk);
			end else begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Every accepted result is compared with the oldest one owed.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (due_replies.size() == 0) begin
				$error("unexpected result: out_conn %0d out_tag %h kind %0d last %0d",
					rsp_if.out_conn, rsp_if.out_tag, rsp_if.kind, rsp_if.last);
				mismatches++;
			end else begin
				want = due_replies[0];
				due_replies.delete(0);
				if (rsp_if.out_conn !== want.conn) begin
					$error("out_conn: expected %0d, got %0d", want.conn, rsp_if.out_conn);
					mismatches++;
				end
				if (rsp_if.out_tag !== want.tag) begin
					$error("out_tag: expected %h, got %h", want.tag, rsp_if.out_tag);
					mismatches++;
				end
				if (rsp_if.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, rsp_if.kind);
					mismatches++;
				end
				if (rsp_if.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp_if.last);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a run that hangs ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule

// ===== files.f =====
src/rpr_pkg.sv
src/rpr_in_if.sv
src/rpr_out_if.sv
src/rpr_ram.sv
src/rpr_ctrl.sv
src/per_connection_reply_reorder.sv
dv/testbench.sv
